// File: hdl/cfas_pkg.sv
// ----------------------------------------------------------------------------
// cfas_pkg
// shared widths, types and latency figures for the face area pipeline
// ----------------------------------------------------------------------------
package cfas_pkg;

  localparam int CompW  = 16;
  localparam int ProdW  = 32;
  localparam int CrossW = 33;
  localparam int MagW   = 32;
  localparam int SqW    = 64;
  localparam int RootW  = 32;
  localparam int SumW   = 34;

  localparam int CrossLat = 2;
  localparam int SqrLat   = 2;
  localparam int RootLat  = RootW;
  localparam int Lat      = CrossLat + SqrLat + RootLat + 1;

  typedef logic signed [CompW-1:0]  comp_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [SqW-1:0]           sq_t;
  typedef logic [RootW-1:0]         root_t;
  typedef logic [SumW-1:0]          sum_t;

  typedef comp_t  vec_t   [3];
  typedef cross_t cvec_t  [3];

endpackage

// File: hdl/cfas_cross.sv
// ----------------------------------------------------------------------------
// cfas_cross
// two-stage cross products of the pairs 0-1, 0-2 and 1-2
// ----------------------------------------------------------------------------
module cfas_cross import cfas_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  vec_t  v [3],
  output cvec_t c [3]
);

  prod_t prod [3][6];

  for (genvar p = 0; p < 3; p++) begin : g_pair
    localparam int IA = (p == 2) ? 1 : 0;
    localparam int IB = (p == 0) ? 1 : 2;

    always_ff @(posedge clk) begin
      if (en) begin
        prod[p][0] <= v[IA][1] * v[IB][2];
        prod[p][1] <= v[IA][2] * v[IB][1];
        prod[p][2] <= v[IA][2] * v[IB][0];
        prod[p][3] <= v[IA][0] * v[IB][2];
        prod[p][4] <= v[IA][0] * v[IB][1];
        prod[p][5] <= v[IA][1] * v[IB][0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c[p][0] <= CrossW'(prod[p][0]) - CrossW'(prod[p][1]);
        c[p][1] <= CrossW'(prod[p][2]) - CrossW'(prod[p][3]);
        c[p][2] <= CrossW'(prod[p][4]) - CrossW'(prod[p][5]);
      end
    end
  end

endmodule

// File: hdl/cfas_sqr.sv
// ----------------------------------------------------------------------------
// cfas_sqr
// squared lengths of the three cross products, two stages
// ----------------------------------------------------------------------------
module cfas_sqr import cfas_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cvec_t c [3],
  output sq_t   n [3]
);

  sq_t sq [3][3];

  for (genvar p = 0; p < 3; p++) begin : g_pair
    for (genvar j = 0; j < 3; j++) begin : g_comp
      cross_t neg;
      mag_t   mag;
      assign neg = -c[p][j];
      assign mag = c[p][j][CrossW-1] ? neg[MagW-1:0] : c[p][j][MagW-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          sq[p][j] <= SqW'(mag) * SqW'(mag);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n[p] <= sq[p][0] + sq[p][1] + sq[p][2];
      end
    end
  end

endmodule

// File: hdl/cfas_isqrt.sv
// ----------------------------------------------------------------------------
// cfas_isqrt
// floored square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module cfas_isqrt import cfas_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sq_t   n,
  output root_t root
);

  sq_t   rem [RootW];
  root_t acc [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam int B = RootW - 1 - k;
    sq_t   rem_in;
    root_t acc_in;
    sq_t   cand;

    if (k == 0) begin : g_first
      assign rem_in = n;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign acc_in = acc[k-1];
    end

    assign cand = (SqW'(acc_in) << (B + 1)) + (SqW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= cand) begin
          rem[k] <= rem_in - cand;
          acc[k] <= acc_in | (RootW'(1) << B);
        end else begin
          rem[k] <= rem_in;
          acc[k] <= acc_in;
        end
      end
    end
  end

  assign root = acc[RootW-1];

endmodule

// File: hdl/cell_face_area_sum.sv
// ----------------------------------------------------------------------------
// cell_face_area_sum
// total area of the parallelogram faces spanned by each pair of edge vectors
// ----------------------------------------------------------------------------
// Takes one vector triple per cycle while in_stall is low and returns one
// area sum per transfer after two stages of cross products, two of squaring
// and summing, 32 square root stages (one root bit each) and the output adder.
// The whole pipeline advances together; it holds only while a finished result
// is stalled at the output, and the input is stalled for those same cycles.
module cell_face_area_sum import cfas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic signed [15:0] v0_x,
  input  logic signed [15:0] v0_y,
  input  logic signed [15:0] v0_z,
  input  logic signed [15:0] v1_x,
  input  logic signed [15:0] v1_y,
  input  logic signed [15:0] v1_z,
  input  logic signed [15:0] v2_x,
  input  logic signed [15:0] v2_y,
  input  logic signed [15:0] v2_z,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [33:0]      area_sum
);

  logic        en;
  logic [Lat-1:0] valid;
  vec_t        v [3];
  cvec_t       c [3];
  sq_t         n [3];
  root_t       root [3];

  assign en       = !valid[Lat-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = valid[Lat-1];

  assign v[0] = '{v0_x, v0_y, v0_z};
  assign v[1] = '{v1_x, v1_y, v1_z};
  assign v[2] = '{v2_x, v2_y, v2_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[Lat-2:0], in_valid};
    end
  end

  cfas_cross u_cross (.clk(clk), .en(en), .v(v), .c(c));
  cfas_sqr   u_sqr   (.clk(clk), .en(en), .c(c), .n(n));

  for (genvar p = 0; p < 3; p++) begin : g_root
    cfas_isqrt u_isqrt (.clk(clk), .en(en), .n(n[p]), .root(root[p]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area_sum <= SumW'(root[0]) + SumW'(root[1]) + SumW'(root[2]);
    end
  end

endmodule
